/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// The including module must provide clk and rst_n (synchronous, active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TSPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define TSPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/tsps_pkg.sv */
// Package for the temperature sensor poll sequencer: widths, register indexes,
// sequencer state type, word structs and the whole-degree conversion.
// No dependencies.
package tsps_pkg;

  localparam int RX_W       = 8;
  localparam int TEMP_W     = 8;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEVICE_ADDRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ERROR_LIMIT    = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] ERROR_LIMIT_RST = CNT_W'(2000);

  typedef enum logic [1:0] {
    ST_IDLE             = 2'd0,
    ST_TRIGGERED        = 2'd1,
    ST_TRIGGER_FINISHED = 2'd2,
    ST_TEMP_REQUESTED   = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic            command_accepted;
    logic            result_ready;
    logic            bus_error;
    logic [RX_W-1:0] rx_high;
    logic [RX_W-1:0] rx_low;
  } poll_in_t;

  typedef struct packed {
    logic                     send_trigger;
    logic                     send_read;
    logic                     bus_reset;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] temperature;
  } poll_out_t;

  // Signed 16-bit word divided by 256, truncated toward zero. A negative word
  // with a nonzero low byte rounds up by one from the plain high byte.
  function automatic logic signed [TEMP_W-1:0] whole_degrees(
      input logic [RX_W-1:0] hi, input logic [RX_W-1:0] lo);
    logic [TEMP_W-1:0] h;
    h = hi;
    if (hi[RX_W-1] && (lo != '0)) begin
      h = hi + TEMP_W'(1);
    end
    return $signed(h);
  endfunction

endpackage

/* design/tsps_if.sv */
// Channel interfaces of the poll sequencer: poll input, result and
// configuration write. Depends on tsps_pkg.
interface tsps_in_if import tsps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command_accepted;
  logic            result_ready;
  logic            bus_error;
  logic [RX_W-1:0] rx_high;
  logic [RX_W-1:0] rx_low;

  modport source (output valid, output command_accepted, output result_ready,
                  output bus_error, output rx_high, output rx_low, input ready);
  modport sink   (input valid, input command_accepted, input result_ready,
                  input bus_error, input rx_high, input rx_low, output ready);
endinterface

interface tsps_out_if import tsps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     send_trigger;
  logic                     send_read;
  logic                     bus_reset;
  logic                     temp_valid;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output send_trigger, output send_read,
                  output bus_reset, output temp_valid, output temperature,
                  input ready);
  modport sink   (input valid, input send_trigger, input send_read,
                  input bus_reset, input temp_valid, input temperature,
                  output ready);
endinterface

interface tsps_cfg_if import tsps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/temp_sensor_poll_sequencer.sv */
// Temperature sensor poll sequencer, top level.
// Depends on tsps_pkg, the channel interfaces in tsps_if.sv and assert_macros.svh.
//
// Usage:
//   in_chan carries one poll word per step: the bus status seen since the last
//   poll (command accepted, result ready, error) and the two received bytes.
//   out_chan returns exactly one result word per poll word, in order: the bus
//   requests (send_trigger, send_read, bus_reset) and, after a good read,
//   temp_valid with the temperature in whole degrees.
//   cfg_chan writes the registers: index 0 is the sensor bus address (taken
//   by the bus side, it has no effect on the result words), index 1 is the
//   error limit. cfg_chan is always ready; write only while the block is idle.
//   A poll word loads the input register at its accepting edge; the sequencer
//   update runs and the result register loads once the result register is
//   empty or being taken. One word per cycle is sustained while the receiver
//   takes each result; the only loop is the sequencer state and error count.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_chan.ready drops only when both are full.
//   Synchronous reset puts the sequencer in idle, clears the error count,
//   sets the error limit to 2000 and empties both registers.
module temp_sensor_poll_sequencer import tsps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tsps_in_if.sink    in_chan,
  tsps_out_if.source out_chan,
  tsps_cfg_if.sink   cfg_chan
);

`include "assert_macros.svh"

  logic        s1_valid_r;
  poll_in_t    s1_r;
  logic        out_valid_r;
  poll_out_t   out_r;
  ctrl_state_t st_r, st_nxt;
  logic [CNT_W-1:0] err_cnt_r, err_cnt_nxt;
  logic [CNT_W-1:0] err_limit_r;
  poll_out_t   res_nxt;
  logic        advance;
  logic        in_fire;
  logic [CNT_W:0] err_inc;

  // The input word moves on when the result register is empty or being taken.
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.command_accepted <= in_chan.command_accepted;
      s1_r.result_ready     <= in_chan.result_ready;
      s1_r.bus_error        <= in_chan.bus_error;
      s1_r.rx_high          <= in_chan.rx_high;
      s1_r.rx_low           <= in_chan.rx_low;
    end
  end

  // The address register lives on the bus side; only the limit is kept here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r <= ERROR_LIMIT_RST;
    end else if (cfg_chan.valid && (cfg_chan.index == CFG_IDX_ERROR_LIMIT)) begin
      err_limit_r <= cfg_chan.data[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      err_cnt_r <= '0;
    end else if (advance) begin
      st_r      <= st_nxt;
      err_cnt_r <= err_cnt_nxt;
    end
  end

  // Compared at 17 bits so a count at the top of its range cannot wrap.
  assign err_inc = {1'b0, err_cnt_r} + (CNT_W+1)'(1);

  always_comb begin
    st_nxt      = st_r;
    err_cnt_nxt = err_cnt_r;
    res_nxt     = '0;
    case (st_r)
      ST_IDLE: begin
        res_nxt.send_trigger = 1'b1;
        if (s1_r.command_accepted) begin
          st_nxt = ST_TRIGGERED;
        end
      end
      ST_TRIGGERED: begin
        if (s1_r.result_ready) begin
          if (s1_r.bus_error) begin
            st_nxt = ST_IDLE;
            if (err_inc > {1'b0, err_limit_r}) begin
              res_nxt.bus_reset = 1'b1;
              err_cnt_nxt       = '0;
            end else begin
              err_cnt_nxt = err_inc[CNT_W-1:0];
            end
          end else begin
            st_nxt      = ST_TRIGGER_FINISHED;
            err_cnt_nxt = '0;
          end
        end
      end
      ST_TRIGGER_FINISHED: begin
        res_nxt.send_read = 1'b1;
        if (s1_r.command_accepted) begin
          st_nxt = ST_TEMP_REQUESTED;
        end
      end
      ST_TEMP_REQUESTED: begin
        if (s1_r.result_ready) begin
          if (s1_r.bus_error) begin
            st_nxt = ST_TRIGGER_FINISHED;
          end else begin
            res_nxt.temp_valid  = 1'b1;
            res_nxt.temperature = whole_degrees(s1_r.rx_high, s1_r.rx_low);
            st_nxt              = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.send_trigger = out_r.send_trigger;
  assign out_chan.send_read    = out_r.send_read;
  assign out_chan.bus_reset    = out_r.bus_reset;
  assign out_chan.temp_valid   = out_r.temp_valid;
  assign out_chan.temperature  = out_r.temperature;

  `TSPS_ASSERT_NEXT(a_state_holds_without_word, !advance, $stable(st_r) && $stable(err_cnt_r))
  `TSPS_ASSERT_NEXT(a_reset_pulse_clears_count, advance && res_nxt.bus_reset, err_cnt_r == '0)
  `TSPS_ASSERT_NEXT(a_read_wait_holds,
      advance && (st_r == ST_TEMP_REQUESTED) && !s1_r.result_ready,
      st_r == ST_TEMP_REQUESTED)
  `TSPS_ASSERT_IMPL(a_temp_excludes_requests, out_valid_r && out_r.temp_valid,
      !out_r.send_trigger && !out_r.send_read && !out_r.bus_reset)

endmodule
